// ===== design/m4i_pkg.sv =====
// ----------------------------------------------------------------------------
// m4i_pkg
// Shared widths, sequencer types and small index tables for the 4x4 matrix
// inverse block.
// ----------------------------------------------------------------------------
package m4i_pkg;

   localparam int EW  = 24;              // element width
   localparam int FB  = 16;              // fractional bits
   localparam int TW  = 16;              // threshold register width
   localparam int MW  = 3 * EW + 2;      // 3x3 minor, signed
   localparam int DW  = 4 * EW + 2;      // determinant, signed
   localparam int AW  = EW + 3;          // multiplier operand A
   localparam int PW  = AW + EW;         // product
   localparam int QW  = EW + 2;          // quotient bits
   localparam int NW  = MW + 2 * FB;     // dividend
   localparam int DSW = DW + QW;         // shifted divisor
   localparam int CW  = (NW > DSW) ? NW : DSW;
   localparam int SHW = TW + 3 * FB;
   localparam int SW  = (SHW > DW) ? SHW : DW;
   localparam int STEPW = $clog2((QW > 24) ? QW : 24);
   localparam int MinorSteps = 24;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MINOR,
      ST_DRAIN,
      ST_DETMAC,
      ST_DETWAIT,
      ST_CHECK,
      ST_JUDGE,
      ST_SING,
      ST_ABS,
      ST_DIV,
      ST_ROUND
   } state_type;

   typedef struct packed {
      state_type        state;
      logic [STEPW-1:0] step;
      logic [3:0]       pos;
      logic             inv_phase;
   } seq_type;

   typedef struct packed {
      logic       en;
      logic       clr;
      logic       neg;
      logic [1:0] shift;
      logic       to_det;
   } acc_ctl_type;

   // Index of the kept row or column after dropping one of four.
   function automatic logic [1:0] skip_idx(input logic [1:0] idx, input logic [1:0] excl);
      return (idx < excl) ? idx : idx + 2'd1;
   endfunction

   // Column picked in row r of the t-th permutation of a 3x3 determinant.
   function automatic logic [1:0] perm_col(input logic [2:0] t, input logic [1:0] r);
      logic [5:0] p;
      unique case (t)
         3'd0: p = {2'd0, 2'd1, 2'd2};
         3'd1: p = {2'd0, 2'd2, 2'd1};
         3'd2: p = {2'd1, 2'd0, 2'd2};
         3'd3: p = {2'd1, 2'd2, 2'd0};
         3'd4: p = {2'd2, 2'd0, 2'd1};
         3'd5: p = {2'd2, 2'd1, 2'd0};
         default: p = 6'd0;
      endcase
      unique case (r)
         2'd0: return p[5:4];
         2'd1: return p[3:2];
         default: return p[1:0];
      endcase
   endfunction

   function automatic logic perm_neg(input logic [2:0] t);
      return (t == 3'd1) || (t == 3'd2) || (t == 3'd5);
   endfunction

endpackage

// ===== design/matrix4_inverse_cofactor.sv =====
// ----------------------------------------------------------------------------
// matrix4_inverse_cofactor
// 4x4 fixed-point matrix inverse by adjugate over determinant, built around
// one shared multiplier and a bit-serial divider.
// ----------------------------------------------------------------------------
//  channel   ports                         handshake
//  request   start, busy, req_*            taken when start & !busy
//  response  rsp_valid, rsp_*              one-cycle strobe, no back-pressure
//  config    csr_valid, csr_ready, csr_*   written when valid & ready
//
// A plain load only writes the store. On the last element four 3x3 minors go
// through the shared multiplier into the determinant, checked against the
// threshold; unless singular, each of the sixteen inverse elements then takes
// a minor and the 26-step divider. Busy stays high throughout. Reset is
// synchronous; the matrix store is not cleared. Results cannot be stalled.
// ----------------------------------------------------------------------------
module matrix4_inverse_cofactor (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [m4i_pkg::EW-1:0]       req_element_value,
   input  logic [1:0]                   req_element_row,
   input  logic [1:0]                   req_element_col,
   input  logic                         req_last_element,
   output logic                         rsp_valid,
   output logic [m4i_pkg::EW-1:0]       rsp_inverse_value,
   output logic [1:0]                   rsp_out_row,
   output logic [1:0]                   rsp_out_col,
   output logic                         rsp_singular,
   output logic                         rsp_saturated,
   output logic                         rsp_last_result,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [m4i_pkg::TW-1:0]       csr_det_threshold
);

   logic [m4i_pkg::EW-1:0]  store_ff [16];
   logic [m4i_pkg::TW-1:0]  thr_ff;
   logic [m4i_pkg::EW-1:0]  x_ff;
   logic [m4i_pkg::DW-1:0]  dmag_ff;
   logic                    det_neg_ff;
   logic                    neg_ff;
   logic                    accept, go, singular;
   m4i_pkg::seq_type        seq;
   logic [2:0]              tri_idx;
   logic [1:0]              sub, ridx, xr, xc;
   logic [3:0]              addr;
   logic [m4i_pkg::EW-1:0]  rd;
   logic signed [m4i_pkg::AW-1:0] mac_a;
   m4i_pkg::acc_ctl_type    ctl;
   logic [m4i_pkg::PW-1:0]  mul_q;
   logic [m4i_pkg::MW-1:0]  minor_q, minor_abs;
   logic [m4i_pkg::DW-1:0]  det_q;
   logic [m4i_pkg::NW-1:0]  num;
   logic [m4i_pkg::QW-1:0]  quot;
   logic                    round_up;
   logic [m4i_pkg::QW:0]    qf, lim, qs;
   logic                    negq, sat;
   logic [m4i_pkg::EW-1:0]  val;

   logic                    rsp_valid_ff;
   logic [m4i_pkg::EW-1:0]  rsp_value_ff;
   logic [1:0]              rsp_row_ff, rsp_col_ff;
   logic                    rsp_sing_ff, rsp_sat_ff, rsp_last_ff;

   assign accept = start && !busy;
   assign go = accept && req_last_element;
   assign csr_ready = 1'b1;

   m4i_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .go       (go),
      .singular (singular),
      .seq      (seq),
      .busy     (busy)
   );

   // Operand addressing: a minor walks six permutations, four steps each.
   always_comb begin
      tri_idx = seq.step[4:2];
      sub = seq.step[1:0];
      ridx = (sub == 2'd3) ? 2'd2 : sub;
      if (seq.inv_phase) begin
         xr = seq.pos[1:0];
         xc = seq.pos[3:2];
      end else begin
         xr = 2'd0;
         xc = seq.pos[1:0];
      end
      if (seq.state == m4i_pkg::ST_DETMAC) begin
         addr = {2'd0, seq.pos[1:0]};
      end else begin
         addr = {m4i_pkg::skip_idx(ridx, xr),
                 m4i_pkg::skip_idx(m4i_pkg::perm_col(tri_idx, ridx), xc)};
      end
      rd = store_ff[addr];
   end

   always_comb begin
      mac_a = {{(m4i_pkg::AW-m4i_pkg::EW){x_ff[m4i_pkg::EW-1]}}, x_ff};
      ctl = '0;
      if (seq.state == m4i_pkg::ST_MINOR) begin
         ctl.neg = m4i_pkg::perm_neg(tri_idx);
         if (sub == 2'd2) begin
            mac_a = {{(m4i_pkg::AW-m4i_pkg::EW){1'b0}}, mul_q[m4i_pkg::EW-1:0]};
            ctl.en = 1'b1;
            ctl.clr = (tri_idx == 3'd0);
         end else if (sub == 2'd3) begin
            ctl.en = 1'b1;
            ctl.shift = 2'd1;
         end
      end else if (seq.state == m4i_pkg::ST_DETMAC) begin
         ctl.en = 1'b1;
         ctl.to_det = 1'b1;
         ctl.neg = seq.pos[0];
         ctl.shift = seq.step[1:0];
         ctl.clr = (seq.pos[1:0] == 2'd0) && (seq.step[1:0] == 2'd0);
         unique case (seq.step[1:0])
            2'd0: mac_a = {{(m4i_pkg::AW-m4i_pkg::EW){1'b0}}, minor_q[m4i_pkg::EW-1:0]};
            2'd1: mac_a = {{(m4i_pkg::AW-m4i_pkg::EW){1'b0}},
                           minor_q[2*m4i_pkg::EW-1:m4i_pkg::EW]};
            default: mac_a = {minor_q[m4i_pkg::MW-1], minor_q[m4i_pkg::MW-1:2*m4i_pkg::EW]};
         endcase
      end
   end

   m4i_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .op_a    (mac_a),
      .op_b    (rd),
      .ctl     (ctl),
      .mul_q   (mul_q),
      .minor_q (minor_q),
      .det_q   (det_q)
   );

   assign minor_abs = minor_q[m4i_pkg::MW-1] ? -minor_q : minor_q;
   assign num = {minor_abs, {(2*m4i_pkg::FB){1'b0}}};

   m4i_div u_div (
      .clock    (clock),
      .load     (seq.state == m4i_pkg::ST_ABS),
      .run      (seq.state == m4i_pkg::ST_DIV),
      .num      (num),
      .den      (dmag_ff),
      .quot     (quot),
      .round_up (round_up)
   );

   assign singular = (dmag_ff == '0) ||
                     (m4i_pkg::SW'(dmag_ff) <
                      (m4i_pkg::SW'(thr_ff) << (3 * m4i_pkg::FB)));

   // Rounding and saturation of the quotient.
   always_comb begin
      qf = (m4i_pkg::QW + 1)'(quot) + (m4i_pkg::QW + 1)'(round_up);
      negq = neg_ff && (qf != '0);
      lim = (m4i_pkg::QW + 1)'(1) << (m4i_pkg::EW - 1);
      if (!negq) begin
         lim = lim - 1'b1;
      end
      sat = (qf > lim);
      qs = sat ? lim : qf;
      val = negq ? -qs[m4i_pkg::EW-1:0] : qs[m4i_pkg::EW-1:0];
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         store_ff[{req_element_row, req_element_col}] <= req_element_value;
      end
      if (seq.state == m4i_pkg::ST_MINOR && sub == 2'd0) begin
         x_ff <= rd;
      end else if (seq.state == m4i_pkg::ST_MINOR && sub == 2'd2) begin
         x_ff <= mul_q[2*m4i_pkg::EW-1:m4i_pkg::EW];
      end
      if (seq.state == m4i_pkg::ST_CHECK) begin
         dmag_ff <= det_q[m4i_pkg::DW-1] ? -det_q : det_q;
         det_neg_ff <= det_q[m4i_pkg::DW-1];
      end
      if (seq.state == m4i_pkg::ST_ABS) begin
         neg_ff <= minor_q[m4i_pkg::MW-1] ^ det_neg_ff ^ seq.pos[0] ^ seq.pos[2];
      end
      if (seq.state == m4i_pkg::ST_SING) begin
         rsp_value_ff <= '0;
         rsp_row_ff <= 2'd0;
         rsp_col_ff <= 2'd0;
         rsp_sing_ff <= 1'b1;
         rsp_sat_ff <= 1'b0;
         rsp_last_ff <= 1'b1;
      end else begin
         rsp_value_ff <= val;
         rsp_row_ff <= seq.pos[3:2];
         rsp_col_ff <= seq.pos[1:0];
         rsp_sing_ff <= 1'b0;
         rsp_sat_ff <= sat;
         rsp_last_ff <= (seq.pos == 4'd15);
      end
      if (reset) begin
         thr_ff <= m4i_pkg::TW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            thr_ff <= csr_det_threshold;
         end
         rsp_valid_ff <= (seq.state == m4i_pkg::ST_ROUND) ||
                         (seq.state == m4i_pkg::ST_SING);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_inverse_value = rsp_value_ff;
   assign rsp_out_row = rsp_row_ff;
   assign rsp_out_col = rsp_col_ff;
   assign rsp_singular = rsp_sing_ff;
   assign rsp_saturated = rsp_sat_ff;
   assign rsp_last_result = rsp_last_ff;

endmodule

// ===== design/m4i_mac.sv =====
// ----------------------------------------------------------------------------
// m4i_mac
// Shared signed multiplier with a registered product and two accumulators,
// one for the current minor and one for the determinant.
// ----------------------------------------------------------------------------
module m4i_mac (
   input  logic                        clock,
   input  logic                        reset,
   input  logic signed [m4i_pkg::AW-1:0] op_a,
   input  logic signed [m4i_pkg::EW-1:0] op_b,
   input  m4i_pkg::acc_ctl_type        ctl,
   output logic [m4i_pkg::PW-1:0]      mul_q,
   output logic [m4i_pkg::MW-1:0]      minor_q,
   output logic [m4i_pkg::DW-1:0]      det_q
);

   logic signed [m4i_pkg::PW-1:0] mul_ff;
   m4i_pkg::acc_ctl_type          ctl_ff;
   logic [m4i_pkg::MW-1:0]        minor_ff, minor_in;
   logic [m4i_pkg::DW-1:0]        det_ff, det_in;
   logic [m4i_pkg::DW-1:0]        prod_ext, term;

   always_ff @(posedge clock) begin
      mul_ff <= op_a * op_b;
      minor_ff <= minor_in;
      det_ff <= det_in;
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl;
      end
   end

   // The add follows the product in the next cycle, under the delayed control.
   always_comb begin
      prod_ext = {{(m4i_pkg::DW-m4i_pkg::PW){mul_ff[m4i_pkg::PW-1]}}, mul_ff};
      unique case (ctl_ff.shift)
         2'd0: term = prod_ext;
         2'd1: term = prod_ext << m4i_pkg::EW;
         default: term = prod_ext << (2 * m4i_pkg::EW);
      endcase
      if (ctl_ff.neg) begin
         term = -term;
      end
      minor_in = minor_ff;
      det_in = det_ff;
      if (ctl_ff.en && !ctl_ff.to_det) begin
         minor_in = (ctl_ff.clr ? '0 : minor_ff) + term[m4i_pkg::MW-1:0];
      end
      if (ctl_ff.en && ctl_ff.to_det) begin
         det_in = (ctl_ff.clr ? '0 : det_ff) + term;
      end
   end

   assign mul_q = mul_ff;
   assign minor_q = minor_ff;
   assign det_q = det_ff;

endmodule

// ===== design/m4i_div.sv =====
// ----------------------------------------------------------------------------
// m4i_div
// Restoring divider, one quotient bit a cycle, with a round-half-up flag.
// ----------------------------------------------------------------------------
module m4i_div (
   input  logic                    clock,
   input  logic                    load,
   input  logic                    run,
   input  logic [m4i_pkg::NW-1:0]  num,
   input  logic [m4i_pkg::DW-1:0]  den,
   output logic [m4i_pkg::QW-1:0]  quot,
   output logic                    round_up
);

   logic [m4i_pkg::NW-1:0]  rem_ff, rem_in;
   logic [m4i_pkg::DSW-1:0] dsh_ff, dsh_in;
   logic [m4i_pkg::QW-1:0]  q_ff, q_in;
   logic [m4i_pkg::DW-1:0]  den_ff;
   logic [m4i_pkg::CW-1:0]  rem_w, dsh_w, diff;
   logic [m4i_pkg::CW:0]    rem2, den2;

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff <= q_in;
      if (load) begin
         den_ff <= den;
      end
   end

   always_comb begin
      rem_w = m4i_pkg::CW'(rem_ff);
      dsh_w = m4i_pkg::CW'(dsh_ff);
      diff = rem_w - dsh_w;
      rem_in = rem_ff;
      dsh_in = dsh_ff;
      q_in = q_ff;
      if (load) begin
         rem_in = num;
         dsh_in = m4i_pkg::DSW'(den) << (m4i_pkg::QW - 1);
         q_in = '0;
      end else if (run) begin
         dsh_in = dsh_ff >> 1;
         if (rem_w >= dsh_w) begin
            rem_in = diff[m4i_pkg::NW-1:0];
            q_in = {q_ff[m4i_pkg::QW-2:0], 1'b1};
         end else begin
            q_in = {q_ff[m4i_pkg::QW-2:0], 1'b0};
         end
      end
      rem2 = {m4i_pkg::CW'(rem_ff), 1'b0};
      den2 = (m4i_pkg::CW + 1)'(den_ff);
      round_up = (rem2 >= den2);
   end

   assign quot = q_ff;

endmodule

// ===== design/m4i_ctrl.sv =====
// ----------------------------------------------------------------------------
// m4i_ctrl
// Sequencer: determinant by four minors, singularity check, then either one
// singular result or one minor and one division for each of sixteen elements.
// ----------------------------------------------------------------------------
module m4i_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             go,
   input  logic             singular,
   output m4i_pkg::seq_type seq,
   output logic             busy
);

   m4i_pkg::state_type           state_ff, state_in;
   logic [m4i_pkg::STEPW-1:0]    step_ff, step_in;
   logic [3:0]                   pos_ff, pos_in;
   logic                         ph_ff, ph_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= m4i_pkg::ST_IDLE;
         step_ff <= '0;
         pos_ff <= '0;
         ph_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         pos_ff <= pos_in;
         ph_ff <= ph_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      pos_in = pos_ff;
      ph_in = ph_ff;
      unique case (state_ff)
         m4i_pkg::ST_IDLE: begin
            if (go) begin
               state_in = m4i_pkg::ST_MINOR;
               step_in = '0;
               pos_in = '0;
               ph_in = 1'b0;
            end
         end
         m4i_pkg::ST_MINOR: begin
            if (step_ff == m4i_pkg::STEPW'(m4i_pkg::MinorSteps - 1)) begin
               state_in = m4i_pkg::ST_DRAIN;
               step_in = '0;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         m4i_pkg::ST_DRAIN: begin
            state_in = ph_ff ? m4i_pkg::ST_ABS : m4i_pkg::ST_DETMAC;
            step_in = '0;
         end
         m4i_pkg::ST_DETMAC: begin
            if (step_ff == m4i_pkg::STEPW'(2)) begin
               state_in = m4i_pkg::ST_DETWAIT;
               step_in = '0;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         m4i_pkg::ST_DETWAIT: begin
            if (pos_ff[1:0] == 2'd3) begin
               state_in = m4i_pkg::ST_CHECK;
            end else begin
               state_in = m4i_pkg::ST_MINOR;
               pos_in = pos_ff + 1'b1;
            end
         end
         m4i_pkg::ST_CHECK: state_in = m4i_pkg::ST_JUDGE;
         m4i_pkg::ST_JUDGE: begin
            if (singular) begin
               state_in = m4i_pkg::ST_SING;
            end else begin
               state_in = m4i_pkg::ST_MINOR;
               pos_in = '0;
               ph_in = 1'b1;
            end
         end
         m4i_pkg::ST_SING: state_in = m4i_pkg::ST_IDLE;
         m4i_pkg::ST_ABS: begin
            state_in = m4i_pkg::ST_DIV;
            step_in = '0;
         end
         m4i_pkg::ST_DIV: begin
            if (step_ff == m4i_pkg::STEPW'(m4i_pkg::QW - 1)) begin
               state_in = m4i_pkg::ST_ROUND;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         m4i_pkg::ST_ROUND: begin
            if (pos_ff == 4'd15) begin
               state_in = m4i_pkg::ST_IDLE;
            end else begin
               state_in = m4i_pkg::ST_MINOR;
               step_in = '0;
               pos_in = pos_ff + 1'b1;
            end
         end
         default: state_in = m4i_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      seq.state = state_ff;
      seq.step = step_ff;
      seq.pos = pos_ff;
      seq.inv_phase = ph_ff;
      busy = (state_ff != m4i_pkg::ST_IDLE);
   end

endmodule

// ===== test/m4i_checker.sv =====
// ----------------------------------------------------------------------------
// m4i_checker
// Watches the element, result and threshold channels of the 4x4 matrix
// inverse block, keeps its own copy of the matrix and threshold, works out
// the inverse exactly in wide integers and compares every result in order.
// ----------------------------------------------------------------------------
module m4i_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  logic [m4i_pkg::EW-1:0] req_element_value,
   input  logic [1:0]             req_element_row,
   input  logic [1:0]             req_element_col,
   input  logic                   req_last_element,
   input  logic                   rsp_valid,
   input  logic [m4i_pkg::EW-1:0] rsp_inverse_value,
   input  logic [1:0]             rsp_out_row,
   input  logic [1:0]             rsp_out_col,
   input  logic                   rsp_singular,
   input  logic                   rsp_saturated,
   input  logic                   rsp_last_result,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [m4i_pkg::TW-1:0] csr_det_threshold,
   output int                     pending,
   output int                     errors
);

   typedef logic signed [127:0] wide_type;

   typedef struct packed {
      logic [m4i_pkg::EW-1:0] value;
      logic [1:0]             row;
      logic [1:0]             col;
      logic                   singular;
      logic                   saturated;
      logic                   last;
   } inv_elem_type;

   logic signed [m4i_pkg::EW-1:0] matrix_copy [16];
   logic [m4i_pkg::TW-1:0]        threshold;
   inv_elem_type                  inverse_queue [$];

   assign pending = inverse_queue.size();

   function automatic wide_type entry(input int r, input int c);
      return wide_type'(matrix_copy[r * 4 + c]);
   endfunction

   // Determinant of the 3x3 submatrix left after dropping row xr and column xc.
   function automatic wide_type minor_det(input int xr, input int xc);
      int       rs [3];
      int       cs [3];
      int       n;
      wide_type a [3][3];
      n = 0;
      for (int t = 0; t < 4; t++) if (t != xr) begin rs[n] = t; n++; end
      n = 0;
      for (int t = 0; t < 4; t++) if (t != xc) begin cs[n] = t; n++; end
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) a[i][j] = entry(rs[i], cs[j]);
      return a[0][0] * (a[1][1] * a[2][2] - a[1][2] * a[2][1])
           - a[0][1] * (a[1][0] * a[2][2] - a[1][2] * a[2][0])
           + a[0][2] * (a[1][0] * a[2][1] - a[1][1] * a[2][0]);
   endfunction

   task automatic predict_inverse();
      wide_type     det, mag, cof, num, quot, remd, lim;
      logic         neg, sat;
      inv_elem_type e;
      det = '0;
      for (int j = 0; j < 4; j++) begin
         if (j % 2 == 0) det = det + entry(0, j) * minor_det(0, j);
         else            det = det - entry(0, j) * minor_det(0, j);
      end
      mag = (det < 0) ? -det : det;
      if (mag == 0 || mag < (wide_type'(threshold) <<< (3 * m4i_pkg::FB))) begin
         e = '{value: '0, row: 2'd0, col: 2'd0, singular: 1'b1, saturated: 1'b0,
               last: 1'b1};
         inverse_queue.push_back(e);
         return;
      end
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            cof  = minor_det(j, i);
            neg  = ((cof < 0) != (det < 0)) ^ ((i + j) % 2 == 1);
            num  = ((cof < 0) ? -cof : cof) <<< (2 * m4i_pkg::FB);
            quot = num / mag;
            remd = num % mag;
            // Round half away from zero on the magnitude.
            if ((remd <<< 1) >= mag) quot = quot + 1;
            if (quot == 0) neg = 1'b0;
            lim = neg ? (wide_type'(1) <<< (m4i_pkg::EW - 1))
                      : ((wide_type'(1) <<< (m4i_pkg::EW - 1)) - 1);
            sat = quot > lim;
            if (sat) quot = lim;
            if (neg) quot = -quot;
            e = '{value: quot[m4i_pkg::EW-1:0], row: 2'(i), col: 2'(j), singular: 1'b0,
                  saturated: sat, last: (i == 3 && j == 3)};
            inverse_queue.push_back(e);
         end
      end
   endtask

   always @(posedge clock) begin
      inv_elem_type want;
      if (reset) begin
         threshold = m4i_pkg::TW'(1);
         inverse_queue.delete();
         errors = 0;
      end else begin
         if (csr_valid && csr_ready) threshold = csr_det_threshold;
         if (rsp_valid) begin
            if (inverse_queue.size() == 0) begin
               $display("%0t: unexpected result value %h row %0d col %0d", $time,
                        rsp_inverse_value, rsp_out_row, rsp_out_col);
               errors++;
            end else begin
               want = inverse_queue.pop_front();
               if (rsp_inverse_value !== want.value) begin
                  $display("%0t: inverse_value expected %h actual %h", $time,
                           want.value, rsp_inverse_value);
                  errors++;
               end
               if (rsp_out_row !== want.row) begin
                  $display("%0t: out_row expected %0d actual %0d", $time, want.row,
                           rsp_out_row);
                  errors++;
               end
               if (rsp_out_col !== want.col) begin
                  $display("%0t: out_col expected %0d actual %0d", $time, want.col,
                           rsp_out_col);
                  errors++;
               end
               if (rsp_singular !== want.singular) begin
                  $display("%0t: singular expected %b actual %b", $time,
                           want.singular, rsp_singular);
                  errors++;
               end
               if (rsp_saturated !== want.saturated) begin
                  $display("%0t: saturated expected %b actual %b", $time,
                           want.saturated, rsp_saturated);
                  errors++;
               end
               if (rsp_last_result !== want.last) begin
                  $display("%0t: last_result expected %b actual %b", $time,
                           want.last, rsp_last_result);
                  errors++;
               end
            end
         end
         if (start && !busy) begin
            matrix_copy[{req_element_row, req_element_col}] = req_element_value;
            if (req_last_element) predict_inverse();
         end
      end
   end

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the 4x4 matrix inverse block: directed matrices covering
// identity, extreme elements, zero determinant and saturation, then random
// well-conditioned and wild matrices under several thresholds. Checking is
// done by m4i_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

   localparam logic signed [m4i_pkg::EW-1:0] ONE  = m4i_pkg::EW'(1 << m4i_pkg::FB);
   localparam logic signed [m4i_pkg::EW-1:0] VMAX = {1'b0, {(m4i_pkg::EW-1){1'b1}}};
   localparam logic signed [m4i_pkg::EW-1:0] VMIN = {1'b1, {(m4i_pkg::EW-1){1'b0}}};

   logic                   clock, reset, start, busy;
   logic [m4i_pkg::EW-1:0] req_element_value;
   logic [1:0]             req_element_row, req_element_col;
   logic                   req_last_element;
   logic                   rsp_valid;
   logic [m4i_pkg::EW-1:0] rsp_inverse_value;
   logic [1:0]             rsp_out_row, rsp_out_col;
   logic                   rsp_singular, rsp_saturated, rsp_last_result;
   logic                   csr_valid, csr_ready;
   logic [m4i_pkg::TW-1:0] csr_det_threshold;
   int                     pending, errors;

   matrix4_inverse_cofactor dut (.*);
   m4i_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic idle_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) return;
      if (pick < 90) repeat ($urandom_range(1, 3)) @(negedge clock);
      else repeat ($urandom_range(20, 60)) @(negedge clock);
   endtask

   // Called after a falling edge; returns after the taking edge and an idle gap.
   task automatic load_element(input logic [m4i_pkg::EW-1:0] v, input int r, input int c,
                               input logic last);
      req_element_value = v;
      req_element_row   = 2'(r);
      req_element_col   = 2'(c);
      req_last_element  = last;
      start             = 1'b1;
      while (busy) @(negedge clock);
      @(posedge clock);
      @(negedge clock);
      start = 1'b0;
      idle_gap();
   endtask

   task automatic write_threshold(input logic [m4i_pkg::TW-1:0] t);
      while (pending != 0 || busy) @(negedge clock);
      repeat (10) @(negedge clock);
      csr_det_threshold = t;
      csr_valid         = 1'b1;
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [m4i_pkg::EW-1:0] random_element(input int style, input bit diag);
      int m;
      case (style)
         0: begin
            // Large diagonal, small off-diagonal entries: the inverse is mostly in range.
            m = diag ? $urandom_range(32768, 300000) : $urandom_range(0, 40000) - 20000;
            if (diag && $urandom_range(0, 1)) m = -m;
            return m4i_pkg::EW'(m);
         end
         1: return m4i_pkg::EW'($urandom);
         default: return m4i_pkg::EW'($urandom_range(0, 8) - 4);
      endcase
   endfunction

   task automatic load_matrix(input int style);
      int order [16];
      int k, t;
      for (int i = 0; i < 16; i++) order[i] = i;
      for (int i = 15; i > 0; i--) begin
         k = $urandom_range(0, i);
         t = order[i]; order[i] = order[k]; order[k] = t;
      end
      for (int i = 0; i < 16; i++)
         load_element(random_element(style, order[i] / 4 == order[i] % 4),
                      order[i] / 4, order[i] % 4, i == 15);
   endtask

   task automatic random_phase(input int count);
      int done, pick, n;
      done = 0;
      while (done < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            load_matrix(pick < 40 ? 0 : (pick < 52 ? 1 : 2));
            done += 16;
         end else if (pick < 85) begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
               load_element(random_element($urandom_range(0, 2), 1'b0),
                            $urandom_range(0, 3), $urandom_range(0, 3), i == n - 1);
            done += n;
         end else begin
            load_element(m4i_pkg::EW'($urandom), $urandom_range(0, 3),
                         $urandom_range(0, 3), 1'b0);
            done++;
         end
      end
   endtask

   initial begin
      reset             = 1'b1;
      start             = 1'b0;
      req_element_value = '0;
      req_element_row   = '0;
      req_element_col   = '0;
      req_last_element  = 1'b0;
      csr_valid         = 1'b0;
      csr_det_threshold = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      write_threshold(m4i_pkg::TW'(1));
      // Identity, then extreme and tiny diagonal entries and a zero determinant.
      for (int i = 0; i < 16; i++)
         load_element((i / 4 == i % 4) ? ONE : '0, i / 4, i % 4, i == 15);
      load_element(VMAX, 0, 0, 1'b1);
      load_element(VMIN, 1, 1, 1'b1);
      load_element(m4i_pkg::EW'(1), 2, 2, 1'b1);
      load_element('0, 3, 3, 1'b1);
      load_element(VMIN, 3, 3, 1'b0);
      load_element(VMAX, 3, 0, 1'b1);

      write_threshold('0);
      load_element('0, 3, 0, 1'b0);
      load_element('0, 3, 3, 1'b1);
      random_phase(20);
      write_threshold('1);
      random_phase(20);
      write_threshold(m4i_pkg::TW'($urandom_range(0, 65535)));
      random_phase(20);
      write_threshold(m4i_pkg::TW'($urandom_range(0, 300)));
      random_phase(20);

      while (pending != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (errors == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule
